[rtl/core/rgbls_pkg.sv]
// shared types, constants and colour scaling for the led strip serialiser
package rgbls_pkg;

    localparam int MAX_PIXELS_DEF = 1024;
    localparam int BITS_PER_BYTE  = 8;
    localparam int WORD_BITS      = 3 * BITS_PER_BYTE;
    localparam int BIT_PTR_W      = $clog2(WORD_BITS);
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;

    localparam logic [15:0] LATCH_SAT = 16'hFFFF;

    // register indexes on the configuration port
    localparam logic [2:0] REG_PIXEL_COUNT = 3'd0;
    localparam logic [2:0] REG_BRIGHTNESS  = 3'd1;
    localparam logic [2:0] REG_ONE_HIGH    = 3'd2;
    localparam logic [2:0] REG_ZERO_HIGH   = 3'd3;
    localparam logic [2:0] REG_BIT_PERIOD  = 3'd4;
    localparam logic [2:0] REG_LATCH_TICKS = 3'd5;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_FILL  = 2'd2,
        MODE_START = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_SEND = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CTL_CLEAR = 2'd0,
        CTL_RUN   = 2'd1,
        CTL_FILL  = 2'd2
    } ctl_state_t;

    typedef struct packed {
        logic [10:0] pixel_count;
        logic [7:0]  brightness_level;
        logic [7:0]  one_high_ticks;
        logic [7:0]  zero_high_ticks;
        logic [7:0]  bit_period_ticks;
        logic [15:0] latch_ticks;
    } cfg_t;

    typedef struct packed {
        logic exec;        // item accepted this cycle, result register loads
        logic sweep_step;  // write one store entry of the clear or fill sweep
    } ctl_cmd_t;

    typedef struct packed {
        logic fill_go;     // current item is a fill that walks the store
        logic sweep_done;  // sweep address is on its last entry
    } ctl_sts_t;

    function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [7:0] lvl);
        logic [16:0] prod;
        prod = {9'd0, c} * ({9'd0, lvl} + 17'd1);
        return prod[15:8];
    endfunction

endpackage

[rtl/core/rgbls_regs.sv]
// configuration register file behind the apb port
module rgbls_regs
    import rgbls_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_PIXEL_COUNT: cfg_next.pixel_count      = pwdata[10:0];
                REG_BRIGHTNESS:  cfg_next.brightness_level = pwdata[7:0];
                REG_ONE_HIGH:    cfg_next.one_high_ticks   = pwdata[7:0];
                REG_ZERO_HIGH:   cfg_next.zero_high_ticks  = pwdata[7:0];
                REG_BIT_PERIOD:  cfg_next.bit_period_ticks = pwdata[7:0];
                REG_LATCH_TICKS: cfg_next.latch_ticks      = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PIXEL_COUNT: prdata = {21'd0, cfg_reg.pixel_count};
            REG_BRIGHTNESS:  prdata = {24'd0, cfg_reg.brightness_level};
            REG_ONE_HIGH:    prdata = {24'd0, cfg_reg.one_high_ticks};
            REG_ZERO_HIGH:   prdata = {24'd0, cfg_reg.zero_high_ticks};
            REG_BIT_PERIOD:  prdata = {24'd0, cfg_reg.bit_period_ticks};
            REG_LATCH_TICKS: prdata = {16'd0, cfg_reg.latch_ticks};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_count      <= 11'd0;
            cfg_reg.brightness_level <= 8'd255;
            cfg_reg.one_high_ticks   <= 8'd13;
            cfg_reg.zero_high_ticks  <= 8'd8;
            cfg_reg.bit_period_ticks <= 8'd21;
            cfg_reg.latch_ticks      <= 16'd800;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/rgbls_ctrl.sv]
// controller: handshakes, result valid and the clear and fill sweeps
module rgbls_ctrl
    import rgbls_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       exec;

    assign m_valid = m_valid_reg;

    always_comb begin
        s_ready        = 1'b0;
        state_next     = state_reg;
        cmd.sweep_step = 1'b0;
        unique case (state_reg)
            CTL_CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done) begin
                    state_next = CTL_RUN;
                end
            end
            CTL_RUN: begin
                // a waiting result may leave in the same cycle as the next item enters
                s_ready = !m_valid_reg || m_ready;
                if (s_valid && s_ready && sts.fill_go) begin
                    state_next = CTL_FILL;
                end
            end
            CTL_FILL: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done) begin
                    state_next = CTL_RUN;
                end
            end
            default: state_next = CTL_CLEAR;
        endcase
        exec     = s_valid && s_ready;
        cmd.exec = exec;
        if (exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CTL_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/core/rgbls_datapath.sv]
// datapath: pixel store, colour scaling, latch timer and bit waveform generator
module rgbls_datapath
    import rgbls_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  ctl_cmd_t   cmd,
    output ctl_sts_t   sts,
    input  logic [1:0] s_mode,
    input  logic [9:0] s_pixel_index,
    input  logic [7:0] s_red_value,
    input  logic [7:0] s_green_value,
    input  logic [7:0] s_blue_value,
    output logic       m_line_level,
    output logic       m_busy_res,
    output logic       m_refused
);

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic [WORD_BITS-1:0] pixel_mem [MAX_PIXELS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // clear/fill sweep
    logic [ADDR_W-1:0]    sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]    sweep_last_reg, sweep_last_next;
    logic [WORD_BITS-1:0] sweep_word_reg, sweep_word_next;

    // frame state
    phase_t               phase_reg, phase_next;
    logic [15:0]          latch_reg, latch_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [BIT_PTR_W-1:0] bit_reg, bit_next;
    logic [7:0]           tick_reg, tick_next;
    logic [WORD_BITS-1:0] shift_reg, shift_next;
    logic                 line_reg, line_next;

    // result register
    logic                 m_line_level_reg, m_busy_res_reg, m_refused_reg;
    logic                 refused;

    mode_t                mode;
    logic [CNT_W-1:0]     eff_count;
    logic                 busy;
    logic                 idx_ok;
    logic [WORD_BITS-1:0] item_word;

    // one tick of waveform, from either the running bit or the first bit of a frame
    logic [WORD_BITS-1:0] base_shift;
    logic [7:0]           base_tick;
    logic [BIT_PTR_W-1:0] base_bit;
    logic [CNT_W-1:0]     base_ptr;
    logic [7:0]           high_ticks;
    logic [8:0]           tick_inc;
    logic [BIT_PTR_W:0]   bit_inc;
    logic [CNT_W:0]       ptr_inc;
    logic                 snd_line;
    logic                 snd_end;
    logic [7:0]           snd_tick;
    logic [BIT_PTR_W-1:0] snd_bit;
    logic [CNT_W-1:0]     snd_ptr;
    logic [WORD_BITS-1:0] snd_shift;

    assign mode      = mode_t'(s_mode);
    assign eff_count = (32'(cfg.pixel_count) >= 32'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS)
                                                                 : CNT_W'(cfg.pixel_count);
    assign busy      = (phase_reg != PH_IDLE);
    assign idx_ok    = 32'(s_pixel_index) < 32'(eff_count);
    assign item_word = {scale_ch(s_green_value, cfg.brightness_level),
                        scale_ch(s_red_value, cfg.brightness_level),
                        scale_ch(s_blue_value, cfg.brightness_level)};

    assign sts.fill_go    = (mode == MODE_FILL) && !busy && (eff_count != '0);
    assign sts.sweep_done = (sweep_addr_reg == sweep_last_reg);

    assign m_line_level = m_line_level_reg;
    assign m_busy_res   = m_busy_res_reg;
    assign m_refused    = m_refused_reg;

    // prefetch the next pixel while sending, pixel 0 otherwise
    assign ptr_inc = {1'b0, base_ptr} + 1'b1;
    assign rd_addr = (phase_reg == PH_SEND) ? ADDR_W'(ptr_inc) : '0;

    always_comb begin
        base_shift = (phase_reg == PH_SEND) ? shift_reg : rd_data_reg;
        base_tick  = (phase_reg == PH_SEND) ? tick_reg : 8'd0;
        base_bit   = (phase_reg == PH_SEND) ? bit_reg : '0;
        base_ptr   = (phase_reg == PH_SEND) ? ptr_reg : '0;
        high_ticks = base_shift[WORD_BITS-1] ? cfg.one_high_ticks : cfg.zero_high_ticks;
        snd_line   = (base_tick < high_ticks);
        tick_inc   = {1'b0, base_tick} + 9'd1;
        bit_inc    = {1'b0, base_bit} + 1'b1;
        snd_end    = 1'b0;
        snd_tick   = tick_inc[7:0];
        snd_bit    = base_bit;
        snd_ptr    = base_ptr;
        snd_shift  = base_shift;
        if (tick_inc >= {1'b0, cfg.bit_period_ticks}) begin
            snd_tick  = 8'd0;
            snd_shift = {base_shift[WORD_BITS-2:0], 1'b0};
            if (bit_inc >= (BIT_PTR_W + 1)'(WORD_BITS)) begin
                snd_bit = '0;
                snd_ptr = ptr_inc[CNT_W-1:0];
                if (ptr_inc >= {1'b0, eff_count}) begin
                    snd_end = 1'b1;
                end else begin
                    snd_shift = rd_data_reg;
                end
            end else begin
                snd_bit = bit_inc[BIT_PTR_W-1:0];
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        latch_next = latch_reg;
        ptr_next   = ptr_reg;
        bit_next   = bit_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        line_next  = line_reg;
        refused    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = ADDR_W'(32'(s_pixel_index));
        mem_wdata  = item_word;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        sweep_word_next = sweep_word_reg;

        if (cmd.sweep_step) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = sweep_word_reg;
            if (!sts.sweep_done) begin
                sweep_addr_next = sweep_addr_reg + 1'b1;
            end
        end

        if (cmd.exec) begin
            unique case (mode)
                MODE_TICK: begin
                    if (phase_reg == PH_SEND ||
                        (phase_reg == PH_WAIT && latch_reg >= cfg.latch_ticks)) begin
                        if ((phase_reg == PH_WAIT && eff_count == '0) ||
                            (phase_reg == PH_SEND && snd_end)) begin
                            // frame over, latch timer restarts from zero
                            phase_next = PH_IDLE;
                            latch_next = 16'd0;
                            line_next  = 1'b0;
                        end else begin
                            phase_next = PH_SEND;
                            line_next  = snd_line;
                            tick_next  = snd_tick;
                            bit_next   = snd_bit;
                            ptr_next   = snd_ptr;
                            shift_next = snd_shift;
                        end
                    end else begin
                        line_next = 1'b0;
                        if (latch_reg != LATCH_SAT) begin
                            latch_next = latch_reg + 16'd1;
                        end
                    end
                end
                MODE_WRITE: begin
                    if (busy) begin
                        refused = 1'b1;
                    end else if (idx_ok) begin
                        mem_we = 1'b1;
                    end
                end
                MODE_FILL: begin
                    if (busy) begin
                        refused = 1'b1;
                    end else if (sts.fill_go) begin
                        sweep_addr_next = '0;
                        sweep_last_next = ADDR_W'(32'(eff_count) - 32'd1);
                        sweep_word_next = item_word;
                    end
                end
                MODE_START: begin
                    if (busy) begin
                        refused = 1'b1;
                    end else begin
                        phase_next = PH_WAIT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pixel_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= pixel_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_line_level_reg <= line_next;
            m_busy_res_reg   <= (phase_next != PH_IDLE);
            m_refused_reg    <= refused;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            latch_reg      <= LATCH_SAT;
            ptr_reg        <= '0;
            bit_reg        <= '0;
            tick_reg       <= 8'd0;
            shift_reg      <= '0;
            line_reg       <= 1'b0;
            // reset starts a zeroing sweep over the whole store
            sweep_addr_reg <= '0;
            sweep_last_reg <= ADDR_W'(MAX_PIXELS - 1);
            sweep_word_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            latch_reg      <= latch_next;
            ptr_reg        <= ptr_next;
            bit_reg        <= bit_next;
            tick_reg       <= tick_next;
            shift_reg      <= shift_next;
            line_reg       <= line_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            sweep_word_reg <= sweep_word_next;
        end
    end

endmodule

[rtl/core/rgb_led_strip_serializer_core.sv]
// top level of the one-wire rgb led strip serialiser
//
// input channel s_*: one item per accepted handshake; mode selects tick, pixel
// write, fill or frame start. each item gives exactly one result on m_*: line
// level after the item, busy flag and a refused flag for writes, fills or
// starts that arrive while a frame waits for latch or is being sent.
// results sit in an output register from the cycle after acceptance. with the
// receiver taking results, an item is accepted every cycle, so tick items can
// mark waveform time at clock rate. a fill walks the pixel store one entry a
// cycle, through its single write port: after a fill with n effective pixels
// the input is held off until all n entries are written. a stalled receiver
// holds the result in the output register and s_ready falls until that result
// is taken. after reset a clearing pass zeroes all MAX_PIXELS store entries,
// during which no item is accepted; the apb registers take writes throughout.
// the user must write configuration over apb while the block is idle; not enforced.
module rgb_led_strip_serializer_core
    import rgbls_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [9:0]            s_pixel_index,
    input  logic [7:0]            s_red_value,
    input  logic [7:0]            s_green_value,
    input  logic [7:0]            s_blue_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_line_level,
    output logic                  m_busy_res,
    output logic                  m_refused
);

    cfg_t     cfg;
    ctl_cmd_t cmd;
    ctl_sts_t sts;

    rgbls_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rgbls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rgbls_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd           (cmd),
        .sts           (sts),
        .s_mode        (s_mode),
        .s_pixel_index (s_pixel_index),
        .s_red_value   (s_red_value),
        .s_green_value (s_green_value),
        .s_blue_value  (s_blue_value),
        .m_line_level  (m_line_level),
        .m_busy_res    (m_busy_res),
        .m_refused     (m_refused)
    );

endmodule

[rtl/core/rgbls_checker.sv]
// port-level checker for the serialiser core and its bind
module rgbls_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_line_level,
    input logic m_busy_res,
    input logic m_refused
);

    // store clearing pass holds off items straight after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("item taken during clearing pass");

    // a refused item never ends a frame
    a_refused_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_refused |-> m_busy_res)
        else $error("refused result without busy");

    // the line only goes high inside a frame
    a_line_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_level |-> m_busy_res)
        else $error("line high outside a frame");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_line_level, m_busy_res, m_refused}))
        else $error("stalled result changed or dropped");

endmodule

bind rgb_led_strip_serializer_core rgbls_checker u_rgbls_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_line_level (m_line_level),
    .m_busy_res   (m_busy_res),
    .m_refused    (m_refused)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for the rgb led strip serialiser core
module testbench
    import rgbls_pkg::*;
();

    localparam int CLK_PERIOD     = 8;
    localparam int STRIP_MAX      = MAX_PIXELS_DEF;
    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic line;
        logic busy;
        logic refused;
    } led_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_mode;
    logic [9:0]            s_pixel_index;
    logic [7:0]            s_red_value;
    logic [7:0]            s_green_value;
    logic [7:0]            s_blue_value;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_line_level;
    logic                  m_busy_res;
    logic                  m_refused;

    rgb_led_strip_serializer_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_pixel_index(s_pixel_index), .s_red_value(s_red_value),
        .s_green_value(s_green_value), .s_blue_value(s_blue_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_line_level(m_line_level),
        .m_busy_res(m_busy_res), .m_refused(m_refused)
    );

    // strip model
    cfg_t        strip_cfg;
    logic [23:0] strip_store [STRIP_MAX];
    phase_t      strip_phase;
    logic [15:0] latch_cnt;
    int          pix_ptr;
    int          bit_ptr;
    int          tick_in_bit;
    logic [23:0] shift_word;
    logic        line_now;

    led_result_t line_state_q [$];

    int items_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int frames_done   = 0;
    int refusals      = 0;
    int settings_used = 0;

    bit idling_allowed = 1'b1;
    bit sender_gaps_on = 1'b1;
    bit sink_stalls_on = 1'b1;
    bit long_hold_req  = 1'b0;
    bit sweep_pending  = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic int strip_len();
        return (int'(strip_cfg.pixel_count) < STRIP_MAX) ? int'(strip_cfg.pixel_count)
                                                          : STRIP_MAX;
    endfunction

    function automatic logic [7:0] dim_channel(input logic [7:0] c);
        int prod;
        prod = int'(c) * (int'(strip_cfg.brightness_level) + 1);
        return 8'(prod >> 8);
    endfunction

    function automatic void reset_strip_model();
        foreach (strip_store[i]) strip_store[i] = '0;
        strip_phase                = PH_IDLE;
        latch_cnt                  = LATCH_SAT;
        pix_ptr                    = 0;
        bit_ptr                    = 0;
        tick_in_bit                = 0;
        shift_word                 = '0;
        line_now                   = 1'b0;
        strip_cfg.pixel_count      = 11'd0;
        strip_cfg.brightness_level = 8'd255;
        strip_cfg.one_high_ticks   = 8'd13;
        strip_cfg.zero_high_ticks  = 8'd8;
        strip_cfg.bit_period_ticks = 8'd21;
        strip_cfg.latch_ticks      = 16'd800;
    endfunction

    function automatic void close_frame();
        strip_phase = PH_IDLE;
        latch_cnt   = '0;
        line_now    = 1'b0;
        frames_done++;
    endfunction

    function automatic void pulse_tick();
        logic [7:0] high;
        high        = shift_word[23] ? strip_cfg.one_high_ticks : strip_cfg.zero_high_ticks;
        line_now    = (tick_in_bit < int'(high));
        tick_in_bit++;
        if (tick_in_bit >= int'(strip_cfg.bit_period_ticks)) begin
            tick_in_bit = 0;
            shift_word  = shift_word << 1;
            bit_ptr++;
            if (bit_ptr >= WORD_BITS) begin
                bit_ptr = 0;
                pix_ptr++;
                if (pix_ptr >= strip_len()) begin
                    close_frame();
                end else begin
                    shift_word = strip_store[pix_ptr];
                end
            end
        end
    endfunction

    function automatic void time_tick();
        if (strip_phase == PH_SEND) begin
            pulse_tick();
        end else if (strip_phase == PH_WAIT && latch_cnt >= strip_cfg.latch_ticks) begin
            // latch time is up: this tick is already the first of the frame
            if (strip_len() == 0) begin
                close_frame();
            end else begin
                strip_phase = PH_SEND;
                pix_ptr     = 0;
                bit_ptr     = 0;
                tick_in_bit = 0;
                shift_word  = strip_store[0];
                pulse_tick();
            end
        end else begin
            line_now = 1'b0;
            if (latch_cnt != LATCH_SAT) latch_cnt++;
        end
    endfunction

    function automatic void apply_item(input mode_t md, input logic [9:0] idx,
                                       input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        led_result_t res;
        logic [23:0] word;
        res.refused = 1'b0;
        word        = {dim_channel(g), dim_channel(r), dim_channel(b)};
        if (md == MODE_TICK) begin
            time_tick();
        end else if (strip_phase != PH_IDLE) begin
            res.refused = 1'b1;
            refusals++;
        end else begin
            case (md)
                MODE_WRITE: begin
                    if (int'(idx) < strip_len()) strip_store[idx] = word;
                end
                MODE_FILL: begin
                    for (int i = 0; i < strip_len(); i++) strip_store[i] = word;
                    sweep_pending = 1'b1;
                end
                MODE_START: begin
                    strip_phase = PH_WAIT;
                end
                default: ;
            endcase
        end
        res.line = line_now;
        res.busy = (strip_phase != PH_IDLE);
        line_state_q.push_back(res);
    endfunction

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    endtask

    always @(posedge aclk) begin : result_check
        led_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (line_state_q.size() == 0) begin
                note_mismatch("result with no item pending", 16'h0, 16'h1);
            end else begin
                want = line_state_q.pop_front();
                results_seen++;
                if (m_line_level !== want.line)
                    note_mismatch("line_level", 16'(want.line), 16'(m_line_level));
                if (m_busy_res !== want.busy)
                    note_mismatch("busy_res", 16'(want.busy), 16'(m_busy_res));
                if (m_refused !== want.refused)
                    note_mismatch("refused", 16'(want.refused), 16'(m_refused));
            end
        end
    end

    // receiver: random stalls plus a long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 11);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_led_item(input mode_t md, input logic [9:0] idx,
                                 input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
        if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= md;
        s_pixel_index <= idx;
        s_red_value   <= r;
        s_green_value <= g;
        s_blue_value  <= b;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        apply_item(md, idx, r, g, b);
    endtask

    task automatic send_random_item(input mode_t md);
        send_led_item(md, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_random_item(MODE_TICK);
    endtask

    // ticks until the frame is out, optionally with refused items mixed in
    task automatic finish_frame(input bit noisy);
        while (strip_phase != PH_IDLE) begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_random_item(mode_t'($urandom_range(1, 3)));
            else
                send_random_item(MODE_TICK);
        end
    endtask

    task automatic park_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic settle_for_config();
        park_sender();
        while (line_state_q.size() != 0) @(posedge aclk);
        // a fill keeps sweeping the store after its result has gone out
        repeat (sweep_pending ? STRIP_MAX + 8 : 4) @(posedge aclk);
        sweep_pending = 1'b0;
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_PIXEL_COUNT: strip_cfg.pixel_count      = val[10:0];
            REG_BRIGHTNESS:  strip_cfg.brightness_level = val[7:0];
            REG_ONE_HIGH:    strip_cfg.one_high_ticks   = val[7:0];
            REG_ZERO_HIGH:   strip_cfg.zero_high_ticks  = val[7:0];
            REG_BIT_PERIOD:  strip_cfg.bit_period_ticks = val[7:0];
            REG_LATCH_TICKS: strip_cfg.latch_ticks      = val[15:0];
            default: ;
        endcase
    endtask

    task automatic configure_strip(input int count, input int level, input int one_h,
                                   input int zero_h, input int period, input int latch);
        settle_for_config();
        set_reg(REG_PIXEL_COUNT, 32'(count));
        set_reg(REG_BRIGHTNESS, 32'(level));
        set_reg(REG_ONE_HIGH, 32'(one_h));
        set_reg(REG_ZERO_HIGH, 32'(zero_h));
        set_reg(REG_BIT_PERIOD, 32'(period));
        set_reg(REG_LATCH_TICKS, 32'(latch));
        settings_used++;
    endtask

    // latch counter is saturated out of reset, so even the longest latch is met
    task automatic test_saturated_latch();
        configure_strip(1, 255, 255, 1, 2, 65535);
        send_led_item(MODE_WRITE, 10'd0, 8'h00, 8'hFF, 8'h5A);
        send_led_item(MODE_WRITE, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);
        send_random_item(MODE_START);
        send_ticks(1);
        send_random_item(MODE_WRITE);
        send_random_item(MODE_FILL);
        send_random_item(MODE_START);
        finish_frame(1'b0);
    endtask

    task automatic test_empty_strip();
        configure_strip(0, 255, 13, 8, 21, 1);
        send_led_item(MODE_WRITE, 10'd0, 8'hFF, 8'hFF, 8'hFF);
        send_random_item(MODE_FILL);
        send_random_item(MODE_START);
        finish_frame(1'b0);
        send_ticks(1);
    endtask

    task automatic test_brightness_and_high_time();
        configure_strip(2, 0, 2, 1, 2, 4);
        send_led_item(MODE_WRITE, 10'd1, 8'hFF, 8'hFF, 8'hFF);
        configure_strip(2, 127, 2, 1, 2, 4);
        send_led_item(MODE_WRITE, 10'd0, 8'h80, 8'hFF, 8'h01);
        send_random_item(MODE_START);
        finish_frame(1'b0);
    endtask

    task automatic test_full_store_fill();
        configure_strip(1024, 255, 5, 1, 2, 2);
        send_random_item(MODE_FILL);
        send_led_item(MODE_WRITE, 10'h3FF, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_led_item(MODE_WRITE, 10'h200, 8'h00, 8'h00, 8'h00);
        configure_strip(1, 255, 5, 1, 2, 2);
        send_random_item(MODE_START);
        finish_frame(1'b0);
    endtask

    task automatic test_count_lowered_mid_frame();
        configure_strip(2, 200, 2, 1, 2, 2);
        send_led_item(MODE_WRITE, 10'd0, 8'hC3, 8'h3C, 8'h99);
        send_led_item(MODE_WRITE, 10'd1, 8'h5A, 8'hA5, 8'h66);
        send_random_item(MODE_START);
        send_ticks(20);
        // pixel 0 is on the line now, frame should stop after it
        configure_strip(1, 200, 2, 1, 2, 2);
        finish_frame(1'b0);
    endtask

    // one tick per bit, ones held high for the whole bit and zeros never high
    task automatic test_short_bit_period();
        configure_strip(1, 255, 200, 0, 0, 1);
        send_led_item(MODE_WRITE, 10'd0, 8'hA5, 8'h96, 8'h0F);
        send_random_item(MODE_START);
        finish_frame(1'b1);
    endtask

    task automatic test_result_backpressure();
        configure_strip(1, 255, 2, 1, 2, 3);
        long_hold_req = 1'b1;
        send_random_item(MODE_FILL);
        send_led_item(MODE_WRITE, 10'd0, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_random_item(MODE_START);
        finish_frame(1'b1);
        send_ticks(10);
    endtask

    function automatic int random_high(input int period);
        return ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(1, period + 1);
    endfunction

    task automatic run_pixel_sequence();
        int         n_writes;
        int         len;
        logic [9:0] idx;
        if (idling_allowed) begin
            sender_gaps_on = ($urandom_range(0, 2) != 0);
            sink_stalls_on = ($urandom_range(0, 2) != 0);
        end
        len = strip_len();
        if ($urandom_range(0, 3) == 0) send_random_item(MODE_FILL);
        n_writes = $urandom_range(0, 3);
        repeat (n_writes) begin
            idx = (len > 0 && $urandom_range(0, 3) != 0) ? 10'($urandom_range(0, len - 1))
                                                           : 10'($urandom_range(0, 1023));
            send_led_item(MODE_WRITE, idx, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        send_ticks($urandom_range(0, 3));
        send_random_item(MODE_START);
        finish_frame(1'b1);
    endtask

    task automatic test_random_frames(input int phases, input int per_phase);
        int period;
        int count;
        int level;
        int phase_start;
        repeat (phases) begin
            period = $urandom_range(2, 3);
            count  = ($urandom_range(0, 5) == 0) ? 0 : 1;
            case ($urandom_range(0, 3))
                0:       level = 0;
                1:       level = 255;
                default: level = $urandom_range(0, 255);
            endcase
            configure_strip(count, level, random_high(period), random_high(period), period,
                            $urandom_range(1, 12));
            phase_start = items_sent;
            while (items_sent - phase_start < per_phase) run_pixel_sequence();
        end
    endtask

    task automatic finish_run();
        int waited;
        waited = 0;
        park_sender();
        while (line_state_q.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (16) @(posedge aclk);
        if (line_state_q.size() != 0)
            note_mismatch("results never delivered", 16'(line_state_q.size()), 16'h0);
        $display("%0d items sent, %0d results checked across %0d register settings",
                 items_sent, results_seen, settings_used);
        $display("%0d frames went out on the line, %0d items refused while busy",
                 frames_done, refusals);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    endtask

    initial begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : main_flow
        aresetn       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_valid       <= 1'b0;
        s_mode        <= MODE_TICK;
        s_pixel_index <= '0;
        s_red_value   <= '0;
        s_green_value <= '0;
        s_blue_value  <= '0;
        reset_strip_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_saturated_latch();
        test_empty_strip();
        test_brightness_and_high_time();
        test_full_store_fill();
        test_count_lowered_mid_frame();
        test_short_bit_period();
        test_result_backpressure();
        test_random_frames(1, 20);

        // last stretch runs flat out on both sides
        idling_allowed = 1'b0;
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        test_random_frames(1, 20);

        finish_run();
    end

endmodule
